[rtl/tsf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsf_pkg
// Shared types and constants for the triangle scanline fill core.
// ---------------------------------------------------------------------------
package tsf_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;

  // derived datapath widths
  localparam int NUM_W = COORD_BITS + FRAC_BITS;      // |dx| << FRAC_BITS
  localparam int SL_W  = NUM_W + 1;                   // signed slope
  localparam int D_W   = COORD_BITS + 1;              // row offset
  localparam int PW    = SL_W + D_W;                  // slope * offset
  localparam int EW    = PW + 2;                      // edge accumulator
  localparam int QW    = EW - FRAC_BITS;              // column before clamp
  localparam int CNT_W = $clog2(NUM_W + 1);

  localparam int BIAS_LO   = 32'h800;
  localparam int BIAS_HI   = 32'h801;
  localparam int WIDTH_CAP = 1024;

  // slope slots
  localparam logic [1:0] SL_21 = 2'd0;
  localparam logic [1:0] SL_31 = 2'd1;
  localparam logic [1:0] SL_32 = 2'd2;

  // edge select
  localparam logic EDGE_A = 1'b0;
  localparam logic EDGE_B = 1'b1;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_first;
    logic signed [COORD_BITS-1:0] y_first;
    logic signed [COORD_BITS-1:0] x_second;
    logic signed [COORD_BITS-1:0] y_second;
    logic signed [COORD_BITS-1:0] x_third;
    logic signed [COORD_BITS-1:0] y_third;
    logic [20:0]                  fill_char;
  } in_t;

  typedef struct packed {
    logic [5:0]  row;
    logic [10:0] x_start;
    logic [10:0] x_end;
    logic [20:0] span_char;
    logic        last_row;
  } out_t;

  typedef struct packed {
    logic       load;
    logic       div_go;
    logic [1:0] div_sel;
    logic       mul;
    logic       add;
    logic       edge_sel;
    logic       row;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic has_rows;
    logic last;
  } sts_t;

endpackage
`default_nettype wire

[rtl/tsf_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsf_div
// Restoring divider, one quotient bit per cycle, signed numerator sign,
// unsigned denominator. A zero denominator gives a zero quotient.
// ---------------------------------------------------------------------------
module tsf_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              go,
  input  wire logic [tsf_pkg::NUM_W-1:0]         num,
  input  wire logic                              neg,
  input  wire logic [tsf_pkg::COORD_BITS-1:0]    den,
  output logic                                   done,
  output logic signed [tsf_pkg::SL_W-1:0]        quo
);

  localparam int CB = tsf_pkg::COORD_BITS;
  localparam int NW = tsf_pkg::NUM_W;
  localparam int CW = tsf_pkg::CNT_W;

  logic [CB-1:0] rem_r, rem_nxt;
  logic [NW-1:0] q_r, q_nxt;
  logic [CB-1:0] den_r;
  logic          neg_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          done_r, done_nxt;
  logic [CB:0]   trial;
  logic [CB:0]   diff;
  logic          ge;
  logic [tsf_pkg::SL_W-1:0] mag;

  assign trial = {rem_r, q_r[NW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (go) begin
      rem_nxt = '0;
      q_nxt   = num;
      cnt_nxt = CW'(NW);
    end else if (cnt_r != '0) begin
      rem_nxt  = ge ? diff[CB-1:0] : trial[CB-1:0];
      q_nxt    = {q_r[NW-2:0], ge};
      cnt_nxt  = cnt_r - CW'(1);
      done_nxt = (cnt_r == CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (go) begin
      den_r <= den;
      neg_r <= neg;
    end
  end

  assign mag  = {1'b0, q_r};
  assign done = done_r;
  assign quo  = (den_r == '0) ? '0 : (neg_r ? $signed(-mag) : $signed(mag));

endmodule
`default_nettype wire

[rtl/tsf_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsf_datapath
// Vertex sort, slope division, edge setup and per-row span generation.
// ---------------------------------------------------------------------------
module tsf_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tsf_pkg::cmd_t cmd,
  output tsf_pkg::sts_t      sts,
  input  wire tsf_pkg::in_t  in_data,
  input  wire logic [10:0]   wid,
  input  wire logic [6:0]    hgt,
  output logic               out_valid,
  output tsf_pkg::out_t      out_data
);

  localparam int CB = tsf_pkg::COORD_BITS;
  localparam int FB = tsf_pkg::FRAC_BITS;
  localparam int SW = tsf_pkg::SL_W;
  localparam int DW = tsf_pkg::D_W;
  localparam int PW = tsf_pkg::PW;
  localparam int EW = tsf_pkg::EW;
  localparam int QW = tsf_pkg::QW;
  localparam logic signed [QW-1:0] ONE_Q = QW'(1);
  localparam logic signed [EW-1:0] BLO = EW'(tsf_pkg::BIAS_LO);
  localparam logic signed [EW-1:0] BHI = EW'(tsf_pkg::BIAS_HI);

  function automatic logic signed [EW-1:0] fix_of(input logic signed [CB-1:0] x);
    return $signed({{(EW-CB-FB){x[CB-1]}}, x, {FB{1'b0}}});
  endfunction

  function automatic logic signed [QW-1:0] trunc_col(input logic signed [EW-1:0] v);
    logic signed [QW-1:0] q;
    q = $signed(v[EW-1:FB]);
    if (v[EW-1] && (v[FB-1:0] != '0)) q = q + ONE_Q;
    return q;
  endfunction

  // ---- vertex sort: stable compare-swap network
  logic signed [CB-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
  always_comb begin
    sx0 = in_data.x_first;  sy0 = in_data.y_first;
    sx1 = in_data.x_second; sy1 = in_data.y_second;
    sx2 = in_data.x_third;  sy2 = in_data.y_third;
    tx  = '0;               ty  = '0;
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
  end

  logic signed [CB-1:0] vx0_r, vy0_r, vx1_r, vy1_r, vx2_r, vy2_r;
  logic [20:0]          ch_r;
  logic signed [SW-1:0] s21_r, s31_r, s32_r;
  logic signed [EW-1:0] ea_r, eb_r, base_r;
  logic signed [PW-1:0] prod_r;
  logic [6:0]           row_r;
  logic                 out_valid_r;
  tsf_pkg::out_t        out_r;

  // ---- divider operands
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          dx_mag;
  logic                 div_done;
  logic signed [SW-1:0] div_q;

  always_comb begin
    dx = $signed({vx0_r[CB-1], vx0_r});
    dy = $signed({vy0_r[CB-1], vy0_r});
    case (cmd.div_sel)
      tsf_pkg::SL_21: begin
        dx = $signed({vx1_r[CB-1], vx1_r}) - $signed({vx0_r[CB-1], vx0_r});
        dy = $signed({vy1_r[CB-1], vy1_r}) - $signed({vy0_r[CB-1], vy0_r});
      end
      tsf_pkg::SL_31: begin
        dx = $signed({vx2_r[CB-1], vx2_r}) - $signed({vx0_r[CB-1], vx0_r});
        dy = $signed({vy2_r[CB-1], vy2_r}) - $signed({vy0_r[CB-1], vy0_r});
      end
      default: begin
        dx = $signed({vx2_r[CB-1], vx2_r}) - $signed({vx1_r[CB-1], vx1_r});
        dy = $signed({vy2_r[CB-1], vy2_r}) - $signed({vy1_r[CB-1], vy1_r});
      end
    endcase
  end

  assign dx_mag = dx[CB] ? $unsigned(-dx) : $unsigned(dx);

  tsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.div_go),
    .num   ({dx_mag[CB-1:0], {FB{1'b0}}}),
    .neg   (dx[CB]),
    .den   (dy[CB-1:0]),
    .done  (div_done),
    .quo   (div_q)
  );

  // ---- row range and first-row setup
  logic signed [CB-1:0] ymin;
  logic signed [CB:0]   ymin_e, y2p1, hgt_e, ymax, row_e, row_p1;
  logic signed [DW-1:0] d0, d2;
  logic                 case_a, case_b;
  logic signed [SW-1:0] m_s;
  logic signed [DW-1:0] m_d;
  logic signed [EW-1:0] m_base;

  assign ymin   = vy0_r[CB-1] ? '0 : vy0_r;
  assign ymin_e = $signed({ymin[CB-1], ymin});
  assign y2p1   = $signed({vy2_r[CB-1], vy2_r}) + $signed((CB+1)'(1));
  assign hgt_e  = $signed({{(CB-6){1'b0}}, hgt});
  assign ymax   = (y2p1 < hgt_e) ? y2p1 : hgt_e;
  assign row_e  = $signed({{(CB-6){1'b0}}, row_r});
  assign row_p1 = row_e + $signed((CB+1)'(1));
  assign d0     = ymin_e - $signed({vy0_r[CB-1], vy0_r});
  assign d2     = ymin_e - $signed({vy2_r[CB-1], vy2_r});
  assign case_a = ymin < vy1_r;
  assign case_b = ymin == vy1_r;

  always_comb begin
    if (cmd.edge_sel == tsf_pkg::EDGE_A) begin
      if (case_a) begin
        m_s = s21_r; m_d = d0; m_base = fix_of(vx0_r);
      end else if (case_b) begin
        m_s = '0; m_d = '0; m_base = fix_of(vx1_r);
      end else begin
        m_s = s32_r; m_d = d2; m_base = fix_of(vx2_r);
      end
    end else begin
      if (case_a || (case_b && (vy0_r != vy2_r))) begin
        m_s = s31_r; m_d = d0; m_base = fix_of(vx0_r);
      end else if (case_b) begin
        m_s = '0; m_d = '0; m_base = fix_of(vx2_r);
      end else begin
        m_s = s31_r; m_d = d2; m_base = fix_of(vx2_r);
      end
    end
  end

  // ---- span of the current row
  logic signed [EW-1:0] e_lo, e_hi;
  logic signed [QW-1:0] lo, hi1, wid_q, xs, xe;
  logic signed [EW-1:0] add_val;

  assign e_lo  = (ea_r < eb_r) ? ea_r : eb_r;
  assign e_hi  = (ea_r < eb_r) ? eb_r : ea_r;
  assign lo    = trunc_col(e_lo + BLO);
  assign hi1   = trunc_col(e_hi + BHI) + ONE_Q;
  assign wid_q = $signed({{(QW-11){1'b0}}, wid});

  always_comb begin
    xs = lo[QW-1] ? '0 : ((lo > wid_q) ? wid_q : lo);
    xe = (hi1 < wid_q) ? hi1 : wid_q;
    if (xe < xs) xe = xs;
  end

  assign add_val = base_r + $signed({{(EW-PW){prod_r[PW-1]}}, prod_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vx0_r <= sx0; vy0_r <= sy0;
      vx1_r <= sx1; vy1_r <= sy1;
      vx2_r <= sx2; vy2_r <= sy2;
      ch_r  <= in_data.fill_char;
    end
    if (div_done) begin
      case (cmd.div_sel)
        tsf_pkg::SL_21: s21_r <= div_q;
        tsf_pkg::SL_31: s31_r <= div_q;
        default:        s32_r <= div_q;
      endcase
    end
    if (cmd.mul) begin
      prod_r <= m_s * m_d;
      base_r <= m_base;
    end
    if (cmd.add) begin
      if (cmd.edge_sel == tsf_pkg::EDGE_A) ea_r <= add_val;
      else begin
        eb_r  <= add_val;
        row_r <= ymin[6:0];
      end
    end
    if (cmd.row) begin
      out_r.row       <= row_r[5:0];
      out_r.x_start   <= xs[10:0];
      out_r.x_end     <= xe[10:0];
      out_r.span_char <= ch_r;
      out_r.last_row  <= (row_p1 == ymax);
      ea_r  <= ea_r + $signed({{(EW-SW){(row_e < $signed({vy1_r[CB-1], vy1_r})) ?
               s21_r[SW-1] : s32_r[SW-1]}},
               ((row_e < $signed({vy1_r[CB-1], vy1_r})) ? s21_r : s32_r)});
      eb_r  <= eb_r + $signed({{(EW-SW){s31_r[SW-1]}}, s31_r});
      row_r <= row_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.row;
  end

  assign sts.div_done = div_done;
  assign sts.has_rows = ymin_e < ymax;
  assign sts.last     = (row_p1 == ymax);
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

endmodule
`default_nettype wire

[rtl/tsf_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tsf_ctrl
// Sequencer: load, the slope divisions, setup of edges A and B, row walk.
// ---------------------------------------------------------------------------
module tsf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire tsf_pkg::sts_t sts,
  output tsf_pkg::cmd_t      cmd
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DIV_GO   = 3'd1;
  localparam logic [2:0] ST_DIV_WAIT = 3'd2;
  localparam logic [2:0] ST_MUL      = 3'd3;
  localparam logic [2:0] ST_ADD      = 3'd4;
  localparam logic [2:0] ST_ROW      = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       edge_r, edge_nxt;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    edge_nxt     = edge_r;
    cmd          = '0;
    cmd.div_sel  = idx_r;
    cmd.edge_sel = edge_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          idx_nxt   = tsf_pkg::SL_21;
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (sts.div_done) begin
          if (idx_r == tsf_pkg::SL_32) begin
            edge_nxt  = tsf_pkg::EDGE_A;
            state_nxt = ST_MUL;
          end else begin
            idx_nxt   = idx_r + 2'd1;
            state_nxt = ST_DIV_GO;
          end
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add = 1'b1;
        if (edge_r == tsf_pkg::EDGE_A) begin
          edge_nxt  = tsf_pkg::EDGE_B;
          state_nxt = ST_MUL;
        end else begin
          state_nxt = sts.has_rows ? ST_ROW : ST_IDLE;
        end
      end
      ST_ROW: begin
        cmd.row = 1'b1;
        if (sts.last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      edge_r  <= tsf_pkg::EDGE_A;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      edge_r  <= edge_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

[rtl/triangle_scanline_fill_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_scanline_fill_core
// Scanline fill of one triangle into per-row spans on a character canvas.
// ---------------------------------------------------------------------------
// Usage:
//   Drive in_data and raise start while busy is low; the triangle is taken
//   on that edge and busy stays high until its last span has been issued.
//   Each span appears on out_data for one cycle with out_valid high; the
//   final span of a triangle has last_row set. A triangle covering no canvas
//   row produces no spans.
//   Setup: one shared bit-serial divider computes each of the edge slopes
//   in turn, then the spans follow at one span per cycle. The first span
//   shows in the cycle after the row walk starts.
//   Canvas size is written through the cfg channel (index 0 width, index 1
//   height); the user must write it only while busy is low, which the block
//   itself does not enforce; cfg_ready is always high.
//   Reset (rst_n low, synchronous) returns to idle and sets the canvas to
//   80 x 25. Spans cannot be held off, so out_valid pulses are the only
//   record of each transfer.
// ---------------------------------------------------------------------------
module triangle_scanline_fill_core #(
  parameter int MAX_ROWS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire tsf_pkg::in_t in_data,
  output logic              out_valid,
  output tsf_pkg::out_t     out_data,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [10:0]  cfg_data
);

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  logic [10:0]   width_r;
  logic [6:0]    height_r;
  logic [10:0]   wid_eff;
  logic [6:0]    hgt_eff;
  tsf_pkg::cmd_t cmd;
  tsf_pkg::sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 11'd80;
      height_r <= 7'd25;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_WIDTH)  width_r  <= cfg_data;
      if (cfg_index == CFG_HEIGHT) height_r <= cfg_data[6:0];
    end
  end

  assign cfg_ready = 1'b1;
  assign wid_eff = (width_r > 11'(tsf_pkg::WIDTH_CAP)) ? 11'(tsf_pkg::WIDTH_CAP) : width_r;
  assign hgt_eff = (height_r > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : height_r;

  tsf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  tsf_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .wid       (wid_eff),
    .hgt       (hgt_eff),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
